// ===== hdl/bcm_pkg.sv =====
// Shared widths, codes and pipeline control types for the committee machine classifier.
`default_nettype none

package bcm_pkg;

  // Fixed field widths.
  localparam int DATA_W     = 32;
  localparam int KIND_W     = 2;
  localparam int HID_IDX_W  = 4;
  localparam int WORD_IDX_W = 5;
  localparam int LABEL_W    = 2;
  localparam int ERR_W      = 32;
  localparam int NIN_W      = 11;
  localparam int NHID_W     = 5;
  localparam int CNT_W      = 11;
  localparam int POP_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Bit position of a word's first input is word_index times the word size.
  localparam int WORD_SHIFT = 5;

  // Input item kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_N_INPUTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_HIDDEN = 2'd1;

  // Signed +1 and -1 in two bits.
  localparam logic [LABEL_W-1:0] PRED_POS = 2'b01;
  localparam logic [LABEL_W-1:0] PRED_NEG = 2'b11;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

  // Control carried down the pipeline with each beat.
  typedef struct packed {
    logic                pat;    // pattern word
    logic                start;  // start pass
    logic                last;
    logic [LABEL_W-1:0]  label;
  } ctrl_t;

  // Pattern word and its in-use mask, broadcast to every lane.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] mask;
  } word_t;

endpackage

`default_nettype wire

// ===== hdl/bcm_lane.sv =====
// One hidden unit: weight row memory, mismatch popcount, count accumulator and vote.
`default_nettype none

module bcm_lane #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     adv,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            addr,
  input  wire logic [bcm_pkg::DATA_W-1:0] wr_data,
  input  wire bcm_pkg::word_t           s1_word,
  input  wire bcm_pkg::ctrl_t           s2_ctrl,
  input  wire logic [bcm_pkg::NIN_W-1:0] n_inputs,
  output logic                          vote
);

  logic [bcm_pkg::DATA_W-1:0] mem [DEPTH];
  logic [bcm_pkg::DATA_W-1:0] rdata_r;
  logic [bcm_pkg::POP_W-1:0]  pop_r;
  logic [bcm_pkg::POP_W-1:0]  pop_nxt;
  logic [bcm_pkg::CNT_W-1:0]  cnt_r;
  logic [bcm_pkg::CNT_W-1:0]  cnt_nxt;
  logic [bcm_pkg::CNT_W-1:0]  sum;
  logic [bcm_pkg::CNT_W:0]    sum_wide;
  logic                       vote_r;
  logic                       vote_nxt;

  // Weight row: written by load beats, read registered for pattern beats.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (adv) begin
      rdata_r <= mem[addr];
    end
  end

  // Mismatch popcount as eight nibble sums added together.
  always_comb begin
    logic [bcm_pkg::DATA_W-1:0] diff;
    logic [2:0]                 nib;
    diff    = (s1_word.data ^ rdata_r) & s1_word.mask;
    pop_nxt = '0;
    for (int g = 0; g < bcm_pkg::DATA_W / 4; g++) begin
      nib = 3'(diff[4*g]) + 3'(diff[4*g+1]) + 3'(diff[4*g+2]) + 3'(diff[4*g+3]);
      pop_nxt = pop_nxt + bcm_pkg::POP_W'(nib);
    end
  end

  // Saturating accumulate, vote on the last word, clear after it or on start.
  always_comb begin
    sum_wide = {1'b0, cnt_r} + (bcm_pkg::CNT_W + 1)'(pop_r);
    sum      = sum_wide[bcm_pkg::CNT_W] ? bcm_pkg::CNT_MAX : sum_wide[bcm_pkg::CNT_W-1:0];
    vote_nxt = vote_r;
    cnt_nxt  = cnt_r;
    if (s2_ctrl.start) begin
      cnt_nxt = '0;
    end else if (s2_ctrl.pat) begin
      if (s2_ctrl.last) begin
        vote_nxt = {sum, 1'b0} < {1'b0, n_inputs};
        cnt_nxt  = '0;
      end else begin
        cnt_nxt = sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (adv) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pop_r  <= pop_nxt;
      vote_r <= vote_nxt;
    end
  end

  assign vote = vote_r;

  // Counts are empty right after a pattern closes.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_ctrl.pat && s2_ctrl.last) |=> (cnt_r == '0))
    else $error("mismatch count not cleared after last word");

endmodule

`default_nettype wire

// ===== hdl/bcm_merge.sv =====
// Committee tally of lane votes, label compare, saturating error count and output register.
`default_nettype none

module bcm_merge #(
  parameter int MAX_HIDDEN = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [MAX_HIDDEN-1:0]       votes,
  input  wire bcm_pkg::ctrl_t              s3_ctrl,
  input  wire logic [bcm_pkg::NHID_W-1:0]  num_hidden,
  input  wire logic                        out_stall,
  output logic                             adv,
  output logic                             out_valid,
  output logic signed [bcm_pkg::LABEL_W-1:0] out_prediction,
  output logic                             out_is_error,
  output logic [bcm_pkg::ERR_W-1:0]        out_error_count
);

  localparam int NW = $clog2(MAX_HIDDEN + 1) + 6;
  localparam int NG = (MAX_HIDDEN + 7) / 8;

  bcm_pkg::ctrl_t             s4_ctrl_r;
  logic                       plus_r;
  logic                       plus_nxt;
  logic [NW-1:0]              nh;
  logic [NW-1:0]              ones;
  logic [bcm_pkg::ERR_W-1:0]  err_total_r;
  logic [bcm_pkg::ERR_W-1:0]  err_total_nxt;
  logic                       err;
  logic                       s4_result;
  logic                       out_valid_r;
  logic [bcm_pkg::LABEL_W-1:0] pred_r;
  logic                       is_err_r;
  logic [bcm_pkg::ERR_W-1:0]  count_r;

  // Hidden units in use, capped at the lane count.
  assign nh = (NW'(num_hidden) > NW'(MAX_HIDDEN)) ? NW'(MAX_HIDDEN) : NW'(num_hidden);

  // Count +1 votes of units in use in groups of eight, then add the groups.
  always_comb begin
    logic [3:0] grp;
    ones = '0;
    for (int g = 0; g < NG; g++) begin
      grp = '0;
      for (int b = 0; b < 8; b++) begin
        if ((g * 8 + b < MAX_HIDDEN) && (NW'(g * 8 + b) < nh)) begin
          grp = grp + 4'(votes[(g * 8 + b) % MAX_HIDDEN]);
        end
      end
      ones = ones + NW'(grp);
    end
    // Vote sum ones - (nh - ones) is positive.
    plus_nxt = (ones << 1) > nh;
  end

  // The pipeline holds only when a result meets a full, stalled output.
  assign s4_result = s4_ctrl_r.pat && s4_ctrl_r.last;
  assign adv       = !(out_valid_r && out_stall && s4_result);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctrl_r <= '0;
    end else if (adv) begin
      s4_ctrl_r <= s3_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      plus_r <= plus_nxt;
    end
  end

  // Label compare and saturating error count.
  always_comb begin
    err = (plus_r ? bcm_pkg::PRED_POS : bcm_pkg::PRED_NEG) != s4_ctrl_r.label;
    err_total_nxt = err_total_r;
    if (s4_ctrl_r.start) begin
      err_total_nxt = '0;
    end else if (s4_result && err && (err_total_r != bcm_pkg::ERR_MAX)) begin
      err_total_nxt = err_total_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_total_r <= '0;
    end else if (adv) begin
      err_total_r <= err_total_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r && out_stall) || (adv && s4_result);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s4_result) begin
      pred_r   <= plus_r ? bcm_pkg::PRED_POS : bcm_pkg::PRED_NEG;
      is_err_r <= err;
      count_r  <= err_total_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_prediction  = pred_r;
  assign out_is_error    = is_err_r;
  assign out_error_count = count_r;

  // A result never lowers the running error count.
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s4_result) |=> (err_total_r >= $past(err_total_r)))
    else $error("error count decreased on a result");

  // A shown result is always +1 or -1.
  a_pred_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_prediction == bcm_pkg::PRED_POS || out_prediction == bcm_pkg::PRED_NEG))
    else $error("prediction is not +1 or -1");

endmodule

`default_nettype wire

// ===== hdl/binary_committee_machine_classifier.sv =====
// Top level of the binary committee machine classifier: input decode, lanes and merge.
//
//  Port group | Direction | Flow control     | Beat carries
//  in_*       | in        | valid / stall    | kind, hidden_index, word_index, data, label, last
//  out_*      | out       | valid / stall    | prediction, is_error, error_count
//  cfg_*      | in        | valid / ready    | index, data (n_inputs, num_hidden)
//
// One input beat is taken per cycle while in_stall is low; a result passes the lane pipeline
// after its last word is taken: memory read, popcount, accumulate, tally, output.
// Input stalls only while a result waits at a stalled output and the next one arrives.
// Reset is synchronous; it clears control, counts and the error total, not the weights.
// Configuration is always ready.
`default_nettype none

module binary_committee_machine_classifier #(
  parameter int MAX_HIDDEN = 16,
  parameter int MAX_WORDS  = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bcm_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [bcm_pkg::HID_IDX_W-1:0]     in_hidden_index,
  input  wire logic [bcm_pkg::WORD_IDX_W-1:0]    in_word_index,
  input  wire logic [bcm_pkg::DATA_W-1:0]        in_data,
  input  wire logic signed [bcm_pkg::LABEL_W-1:0] in_label,
  input  wire logic                              in_last,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [bcm_pkg::LABEL_W-1:0]     out_prediction,
  output logic                                   out_is_error,
  output logic [bcm_pkg::ERR_W-1:0]              out_error_count,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bcm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bcm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int WXW = AW + bcm_pkg::WORD_IDX_W;
  localparam int HXW = ((MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1) + bcm_pkg::HID_IDX_W;
  localparam int PW  = bcm_pkg::NIN_W + 1;

  logic                          adv;
  logic                          accept;
  logic [bcm_pkg::NIN_W-1:0]     n_inputs_r;
  logic [bcm_pkg::NHID_W-1:0]    num_hidden_r;
  logic [WXW-1:0]                widx_x;
  logic [HXW-1:0]                hid_x;
  logic                          widx_ok;
  logic                          load_ok;
  logic [AW-1:0]                 addr;
  logic [MAX_HIDDEN-1:0]         wr_en;
  logic [MAX_HIDDEN-1:0]         votes;
  logic [bcm_pkg::DATA_W-1:0]    mask;
  bcm_pkg::ctrl_t                s1_ctrl_nxt;
  bcm_pkg::ctrl_t                s1_ctrl_r;
  bcm_pkg::ctrl_t                s2_ctrl_r;
  bcm_pkg::ctrl_t                s3_ctrl_r;
  bcm_pkg::word_t                s1_word_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_inputs_r   <= bcm_pkg::NIN_W'(1);
      num_hidden_r <= bcm_pkg::NHID_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bcm_pkg::REG_N_INPUTS) begin
        n_inputs_r <= cfg_data[bcm_pkg::NIN_W-1:0];
      end else if (cfg_index == bcm_pkg::REG_NUM_HIDDEN) begin
        num_hidden_r <= cfg_data[bcm_pkg::NHID_W-1:0];
      end
    end
  end

  // Input handshake.
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // Index range checks and weight write enables.
  assign widx_x  = WXW'(in_word_index);
  assign hid_x   = HXW'(in_hidden_index);
  assign widx_ok = widx_x < WXW'(MAX_WORDS);
  assign addr    = widx_x[AW-1:0];
  assign load_ok = accept && (in_kind == bcm_pkg::KIND_LOAD) && widx_ok
                   && (hid_x < HXW'(MAX_HIDDEN));

  // Mask of the word's bits that lie below n_inputs; empty for a word outside the store.
  always_comb begin
    logic [PW-1:0] base;
    logic [PW-1:0] rem;
    base = PW'(in_word_index) << bcm_pkg::WORD_SHIFT;
    rem  = PW'(n_inputs_r) - base;
    if (!widx_ok || (base >= PW'(n_inputs_r))) begin
      mask = '0;
    end else if (rem >= PW'(bcm_pkg::DATA_W)) begin
      mask = '1;
    end else begin
      mask = ~({bcm_pkg::DATA_W{1'b1}} << rem[bcm_pkg::WORD_SHIFT-1:0]);
    end
  end

  // Only pattern and start beats travel down the pipeline.
  always_comb begin
    s1_ctrl_nxt       = '0;
    s1_ctrl_nxt.last  = in_last;
    s1_ctrl_nxt.label = in_label;
    if (accept) begin
      s1_ctrl_nxt.pat   = (in_kind == bcm_pkg::KIND_PAT);
      s1_ctrl_nxt.start = (in_kind == bcm_pkg::KIND_START);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctrl_r <= '0;
      s2_ctrl_r <= '0;
      s3_ctrl_r <= '0;
    end else if (adv) begin
      s1_ctrl_r <= s1_ctrl_nxt;
      s2_ctrl_r <= s1_ctrl_r;
      s3_ctrl_r <= s2_ctrl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_word_r.data <= in_data;
      s1_word_r.mask <= mask;
    end
  end

  // One lane per hidden unit.
  for (genvar h = 0; h < MAX_HIDDEN; h++) begin : g_lane
    assign wr_en[h] = load_ok && (hid_x == HXW'(h));

    bcm_lane #(
      .DEPTH (MAX_WORDS),
      .AW    (AW)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .wr_en    (wr_en[h]),
      .addr     (addr),
      .wr_data  (in_data),
      .s1_word  (s1_word_r),
      .s2_ctrl  (s2_ctrl_r),
      .n_inputs (n_inputs_r),
      .vote     (votes[h])
    );
  end

  bcm_merge #(
    .MAX_HIDDEN (MAX_HIDDEN)
  ) u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .votes           (votes),
    .s3_ctrl         (s3_ctrl_r),
    .num_hidden      (num_hidden_r),
    .out_stall       (out_stall),
    .adv             (adv),
    .out_valid       (out_valid),
    .out_prediction  (out_prediction),
    .out_is_error    (out_is_error),
    .out_error_count (out_error_count)
  );

  // The input is held back only behind a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

  // A pattern beat and a start beat are never the same beat.
  a_ctrl_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_ctrl_r.pat && s1_ctrl_r.start) && !(s3_ctrl_r.pat && s3_ctrl_r.start))
    else $error("pipeline beat marked both pattern and start");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the binary committee machine classifier.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_HID = 16;
  localparam int N_WORDS = 32;
  localparam int SETTLE_CYCLES = 8;
  localparam int BEAT_TARGET = 1450;
  localparam int QUIET_BEATS = 150;
  localparam int IDLE_PCT = 38;

  // Codes outside the package: the unused kind, the odd labels and the spare registers.
  localparam logic [bcm_pkg::KIND_W-1:0] KIND_NONE = 2'd3;
  localparam logic [bcm_pkg::LABEL_W-1:0] LABEL_ZERO = 2'b00;
  localparam logic [bcm_pkg::LABEL_W-1:0] LABEL_MINUS2 = 2'b10;
  localparam logic [bcm_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [bcm_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [bcm_pkg::KIND_W-1:0]     kind;
    logic [bcm_pkg::HID_IDX_W-1:0]  hid;
    logic [bcm_pkg::WORD_IDX_W-1:0] widx;
    logic [bcm_pkg::DATA_W-1:0]     data;
    logic [bcm_pkg::LABEL_W-1:0]    label;
    logic                           last;
  } beat_t;

  typedef struct packed {
    logic [bcm_pkg::LABEL_W-1:0] pred;
    logic                        is_err;
    logic [bcm_pkg::ERR_W-1:0]   count;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [bcm_pkg::KIND_W-1:0] in_kind = '0;
  logic [bcm_pkg::HID_IDX_W-1:0] in_hidden_index = '0;
  logic [bcm_pkg::WORD_IDX_W-1:0] in_word_index = '0;
  logic [bcm_pkg::DATA_W-1:0] in_data = '0;
  logic signed [bcm_pkg::LABEL_W-1:0] in_label = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [bcm_pkg::LABEL_W-1:0] out_prediction;
  logic out_is_error;
  logic [bcm_pkg::ERR_W-1:0] out_error_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bcm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bcm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the classifier state.
  logic [bcm_pkg::DATA_W-1:0] weight_rows [N_HID][N_WORDS];
  logic [bcm_pkg::CNT_W-1:0] miss_tally [N_HID];
  logic [bcm_pkg::ERR_W-1:0] wrong_total;
  logic [bcm_pkg::NIN_W-1:0] n_in_cfg;
  logic [bcm_pkg::NHID_W-1:0] n_hid_cfg;

  verdict_t verdict_q [$];
  verdict_t due;
  int bad_results = 0;
  int beats_sent = 0;
  bit idle_on = 1'b1;

  binary_committee_machine_classifier uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_hidden_index (in_hidden_index),
    .in_word_index   (in_word_index),
    .in_data         (in_data),
    .in_label        (in_label),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_prediction  (out_prediction),
    .out_is_error    (out_is_error),
    .out_error_count (out_error_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The result side stalls at random while idling is enabled.
  always @(negedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
  end

  // Bits of word w that fall below the configured input count.
  function automatic logic [bcm_pkg::DATA_W-1:0] in_use_mask(
      input logic [bcm_pkg::WORD_IDX_W-1:0] w);
    int base;
    int rem;
    base = int'(w) * bcm_pkg::DATA_W;
    if (base >= int'(n_in_cfg)) return '0;
    rem = int'(n_in_cfg) - base;
    if (rem >= bcm_pkg::DATA_W) return '1;
    return (32'h1 << rem) - 32'h1;
  endfunction

  // Advance the mirrored state by one accepted beat and queue any verdict it produces.
  function automatic void classify_beat(input beat_t b);
    logic [bcm_pkg::DATA_W-1:0] mask;
    int tally;
    int votes;
    int nh;
    verdict_t v;
    case (b.kind)
      bcm_pkg::KIND_LOAD: weight_rows[b.hid][b.widx] = b.data;
      bcm_pkg::KIND_START: begin
        wrong_total = '0;
        foreach (miss_tally[h]) miss_tally[h] = '0;
      end
      bcm_pkg::KIND_PAT: begin
        mask = in_use_mask(b.widx);
        for (int h = 0; h < N_HID; h++) begin
          tally = int'(miss_tally[h]) + $countones((b.data ^ weight_rows[h][b.widx]) & mask);
          miss_tally[h] = (tally > int'(bcm_pkg::CNT_MAX)) ? bcm_pkg::CNT_MAX
                                                           : bcm_pkg::CNT_W'(tally);
        end
        if (b.last) begin
          nh = (int'(n_hid_cfg) > N_HID) ? N_HID : int'(n_hid_cfg);
          votes = 0;
          for (int h = 0; h < nh; h++) begin
            votes += (2 * int'(miss_tally[h]) < int'(n_in_cfg)) ? 1 : -1;
          end
          v.pred = (votes > 0) ? bcm_pkg::PRED_POS : bcm_pkg::PRED_NEG;
          v.is_err = (b.label != v.pred);
          if (v.is_err && wrong_total != bcm_pkg::ERR_MAX) wrong_total = wrong_total + 1'b1;
          v.count = wrong_total;
          foreach (miss_tally[h]) miss_tally[h] = '0;
          verdict_q = {verdict_q, v};
        end
      end
      default: ;
    endcase
  endfunction

  function automatic beat_t make_beat(input logic [bcm_pkg::KIND_W-1:0] kind,
                                      input logic [bcm_pkg::HID_IDX_W-1:0] hid,
                                      input logic [bcm_pkg::WORD_IDX_W-1:0] widx,
                                      input logic [bcm_pkg::DATA_W-1:0] data,
                                      input logic [bcm_pkg::LABEL_W-1:0] label,
                                      input logic last);
    beat_t b;
    b.kind = kind;
    b.hid = hid;
    b.widx = widx;
    b.data = data;
    b.label = label;
    b.last = last;
    return b;
  endfunction

  // Present one beat, with random gaps ahead of it, and hold it until accepted.
  task automatic send_beat(input beat_t b);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= b.kind;
    in_hidden_index <= b.hid;
    in_word_index <= b.widx;
    in_data <= b.data;
    in_label <= b.label;
    in_last <= b.last;
    do @(posedge clk); while (in_stall);
    classify_beat(b);
    if (b.kind != KIND_NONE) beats_sent++;
  endtask

  // One pattern word; the hidden index and, before the last word, the label are don't-care.
  task automatic send_word(input int w, input logic [bcm_pkg::DATA_W-1:0] d,
                           input logic last, input logic [bcm_pkg::LABEL_W-1:0] lab);
    send_beat(make_beat(bcm_pkg::KIND_PAT, bcm_pkg::HID_IDX_W'($urandom),
                        bcm_pkg::WORD_IDX_W'(w), d,
                        last ? lab : bcm_pkg::LABEL_W'($urandom), last));
  endtask

  task automatic send_start();
    send_beat(make_beat(bcm_pkg::KIND_START, bcm_pkg::HID_IDX_W'($urandom),
                        bcm_pkg::WORD_IDX_W'($urandom), $urandom,
                        bcm_pkg::LABEL_W'($urandom), 1'($urandom)));
  endtask

  // Stop sending and wait until every queued verdict has come back, then let the pipe empty.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic set_config(input logic [bcm_pkg::CFG_IDX_W-1:0] idx,
                            input logic [bcm_pkg::CFG_DATA_W-1:0] val);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bcm_pkg::REG_N_INPUTS:   n_in_cfg = val;
      bcm_pkg::REG_NUM_HIDDEN: n_hid_cfg = val[bcm_pkg::NHID_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pattern data: random, close to one weight row, or close to its complement.
  function automatic logic [bcm_pkg::DATA_W-1:0] pick_data(input int w, input int style,
                                                           input int h_ref);
    logic [bcm_pkg::DATA_W-1:0] flips;
    flips = $urandom & $urandom & $urandom;
    case (style)
      0: return $urandom;
      1: return weight_rows[h_ref][w] ^ flips;
      default: return ~weight_rows[h_ref][w] ^ flips;
    endcase
  endfunction

  // A well-formed pattern sized to the current input count, now and then with
  // repeated or stray words mixed in.
  task automatic send_random_pattern();
    int nw;
    int style;
    int h_ref;
    int lab_pick;
    logic [bcm_pkg::LABEL_W-1:0] lab;
    nw = (int'(n_in_cfg) + bcm_pkg::DATA_W - 1) / bcm_pkg::DATA_W;
    if (nw < 1) nw = 1;
    if (nw > N_WORDS) nw = N_WORDS;
    style = $urandom_range(2);
    h_ref = $urandom_range(N_HID - 1);
    lab_pick = $urandom_range(19);
    lab = (lab_pick == 0) ? LABEL_ZERO : (lab_pick == 1) ? LABEL_MINUS2 :
          (lab_pick < 11) ? bcm_pkg::PRED_POS : bcm_pkg::PRED_NEG;
    for (int w = 0; w < nw; w++) begin
      if ($urandom_range(19) == 0) send_word(w, pick_data(w, style, h_ref), 1'b0, lab);
      if ($urandom_range(19) == 0) send_word($urandom_range(N_WORDS - 1), $urandom, 1'b0, lab);
      send_word(w, pick_data(w, style, h_ref), w == nw - 1, lab);
    end
  endtask

  // Mostly whole patterns; the rest weight reloads, starts, unknown kinds and cut patterns.
  task automatic run_random_phase(input int n_beats);
    int stop_at;
    int pick;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        send_random_pattern();
      end else if (pick < 87) begin
        send_beat(make_beat(bcm_pkg::KIND_LOAD, bcm_pkg::HID_IDX_W'($urandom),
                            bcm_pkg::WORD_IDX_W'($urandom), $urandom,
                            bcm_pkg::LABEL_W'($urandom), 1'($urandom)));
      end else if (pick < 91) begin
        send_start();
      end else if (pick < 95) begin
        send_beat(make_beat(KIND_NONE, bcm_pkg::HID_IDX_W'($urandom),
                            bcm_pkg::WORD_IDX_W'($urandom), $urandom,
                            bcm_pkg::LABEL_W'($urandom), 1'($urandom)));
      end else begin
        send_word($urandom_range(N_WORDS - 1), $urandom, 1'b0, bcm_pkg::PRED_POS);
      end
    end
  endtask

  // Mostly short patterns, sometimes long ones, now and then an extreme setting.
  task automatic pick_random_config();
    int n;
    int nh;
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) begin
      case ($urandom_range(5))
        0: n = 0;
        1: n = 1;
        2: n = 32;
        3: n = 33;
        4: n = 1024;
        default: n = 2047;
      endcase
    end else if (sel < 3) begin
      n = $urandom_range(1024, 97);
    end else begin
      n = $urandom_range(96, 1);
    end
    if ($urandom_range(9) < 7) begin
      nh = 2 * $urandom_range(7) + 1;
    end else begin
      case ($urandom_range(5))
        0: nh = 0;
        1: nh = 2;
        2: nh = 16;
        3: nh = 17;
        4: nh = 31;
        default: nh = $urandom_range(31);
      endcase
    end
    set_config(bcm_pkg::REG_N_INPUTS, bcm_pkg::CFG_DATA_W'(n));
    set_config(bcm_pkg::REG_NUM_HIDDEN, bcm_pkg::CFG_DATA_W'(nh));
  endtask

  // Fill the whole weight store. Word 0 rows alternate all-zero and all-one.
  task automatic test_weight_load();
    logic [bcm_pkg::DATA_W-1:0] d;
    for (int w = 0; w < N_WORDS; w++) begin
      for (int h = 0; h < N_HID; h++) begin
        d = (w == 0) ? {bcm_pkg::DATA_W{h[0]}} : $urandom;
        send_beat(make_beat(bcm_pkg::KIND_LOAD, bcm_pkg::HID_IDX_W'(h),
                            bcm_pkg::WORD_IDX_W'(w), d,
                            bcm_pkg::LABEL_W'($urandom), 1'($urandom)));
      end
    end
  endtask

  // One input, one hidden unit: both votes and every label code.
  task automatic test_reset_settings();
    send_word(0, '0, 1'b1, bcm_pkg::PRED_POS);
    send_word(0, '1, 1'b1, bcm_pkg::PRED_POS);
    send_word(0, '1, 1'b1, bcm_pkg::PRED_NEG);
    send_word(0, '0, 1'b1, LABEL_ZERO);
    send_word(0, '0, 1'b1, LABEL_MINUS2);
  endtask

  // Unknown kind with last set, start clearing the count, words beyond the inputs
  // in use, and a repeated word.
  task automatic test_kinds_and_start();
    send_beat(make_beat(KIND_NONE, '1, '1, '1, bcm_pkg::PRED_POS, 1'b1));
    send_start();
    send_word(N_WORDS - 1, '1, 1'b0, bcm_pkg::PRED_POS);
    send_word(0, '0, 1'b0, bcm_pkg::PRED_POS);
    send_word(0, '0, 1'b1, bcm_pkg::PRED_NEG);
  endtask

  // Extreme register values, masked upper bits and the spare register indexes.
  task automatic test_config_extremes();
    set_config(bcm_pkg::REG_N_INPUTS, '0);
    send_word(0, '0, 1'b1, bcm_pkg::PRED_NEG);
    set_config(bcm_pkg::REG_N_INPUTS, '1);
    set_config(bcm_pkg::REG_NUM_HIDDEN, bcm_pkg::CFG_DATA_W'(31));
    send_word(0, $urandom, 1'b0, bcm_pkg::PRED_POS);
    send_word(1, $urandom, 1'b1, bcm_pkg::PRED_POS);
    set_config(bcm_pkg::REG_NUM_HIDDEN, '0);
    send_word(0, '0, 1'b1, bcm_pkg::PRED_POS);
    // Upper data bits drop off, leaving sixteen units that tie on an even split.
    set_config(bcm_pkg::REG_N_INPUTS, bcm_pkg::CFG_DATA_W'(1));
    set_config(bcm_pkg::REG_NUM_HIDDEN, bcm_pkg::CFG_DATA_W'(11'h7F0));
    send_word(0, '0, 1'b1, bcm_pkg::PRED_NEG);
    set_config(REG_SPARE_A, bcm_pkg::CFG_DATA_W'(11'h555));
    set_config(REG_SPARE_B, bcm_pkg::CFG_DATA_W'(11'h2AA));
    send_word(0, '1, 1'b1, bcm_pkg::PRED_NEG);
    set_config(bcm_pkg::REG_N_INPUTS, bcm_pkg::CFG_DATA_W'(1024));
    set_config(bcm_pkg::REG_NUM_HIDDEN, bcm_pkg::CFG_DATA_W'(15));
    send_word(31, $urandom, 1'b1, bcm_pkg::PRED_POS);
  endtask

  // Repeating one word drives the mismatch counters into saturation.
  task automatic test_count_saturation();
    set_config(bcm_pkg::REG_N_INPUTS, '1);
    set_config(bcm_pkg::REG_NUM_HIDDEN, bcm_pkg::CFG_DATA_W'(3));
    send_start();
    for (int i = 0; i < 70; i++) begin
      send_word(0, ~weight_rows[0][0], i == 69, bcm_pkg::PRED_NEG);
    end
  endtask

  task automatic test_random_traffic();
    while (beats_sent < BEAT_TARGET - QUIET_BEATS) begin
      pick_random_config();
      run_random_phase($urandom_range(90, 40));
    end
  endtask

  // Back-to-back beats with the result side never stalling.
  task automatic test_no_idle_stretch();
    pick_random_config();
    idle_on = 1'b0;
    run_random_phase(QUIET_BEATS);
    idle_on = 1'b1;
  endtask

  // Compare each accepted result with the oldest queued verdict.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result: prediction %0d is_error %0b error_count %0d",
                 $time, out_prediction, out_is_error, out_error_count);
        bad_results++;
      end else begin
        due = verdict_q.pop_front();
        if (out_prediction !== due.pred) begin
          $display("%0t: prediction expected %0d actual %0d",
                   $time, $signed(due.pred), out_prediction);
          bad_results++;
        end
        if (out_is_error !== due.is_err) begin
          $display("%0t: is_error expected %0b actual %0b", $time, due.is_err, out_is_error);
          bad_results++;
        end
        if (out_error_count !== due.count) begin
          $display("%0t: error_count expected %0d actual %0d",
                   $time, due.count, out_error_count);
          bad_results++;
        end
      end
    end
  end

  initial begin
    n_in_cfg = bcm_pkg::NIN_W'(1);
    n_hid_cfg = bcm_pkg::NHID_W'(1);
    wrong_total = '0;
    foreach (miss_tally[h]) miss_tally[h] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_weight_load();
    test_reset_settings();
    test_kinds_and_start();
    test_config_extremes();
    test_count_saturation();
    test_random_traffic();
    test_no_idle_stretch();
    drain_results();

    if (bad_results == 0 && verdict_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
